[hdl/rk4_pkg.sv]
// ============================================================================
// rk4_pkg
// Shared types, constants, saturating helpers and the microcode ROM of the
// RK4 complex step unit.
// ============================================================================
package rk4_pkg;

  // Number format: signed Q16.16 held in 32 bits
  localparam int DATA_W  = 32;
  localparam int FRAC_W  = 16;
  localparam int STEP_W  = 17;
  localparam int COUNT_W = 10;
  localparam int PROD_W  = 2 * DATA_W;
  localparam int PC_W    = 6;

  typedef logic signed [DATA_W-1:0] data_t;

  localparam data_t DATA_MAX  = {1'b0, {(DATA_W-1){1'b1}}};
  localparam data_t DATA_MIN  = {1'b1, {(DATA_W-1){1'b0}}};
  localparam data_t FOUR_FX   = data_t'(32'sd4 <<< FRAC_W);
  localparam data_t ZERO_FX   = '0;
  localparam logic [DATA_W-1:0] RECIP_SIX = 32'd715827883;

  // Configuration register indexes
  localparam logic CFG_STEP_SIZE  = 1'b0;
  localparam logic CFG_STEP_COUNT = 1'b1;

  // Datapath operations
  localparam logic [3:0] OP_NEG  = 4'd0;   // t = -arg
  localparam logic [3:0] OP_DBL  = 4'd1;   // t = t + t
  localparam logic [3:0] OP_ADDX = 4'd2;   // t = t + selected x
  localparam logic [3:0] OP_ADDC = 4'd3;   // t = t + constant
  localparam logic [3:0] OP_MULK = 4'd4;   // p = |t| * dx
  localparam logic [3:0] OP_SATK = 4'd5;   // k = signed, saturated p >> FRAC_W
  localparam logic [3:0] OP_SUMI = 4'd6;   // s = k
  localparam logic [3:0] OP_SUMA = 4'd7;   // s = s + k
  localparam logic [3:0] OP_ARGH = 4'd8;   // arg = y + k/2
  localparam logic [3:0] OP_ARGF = 4'd9;   // arg = y + k
  localparam logic [3:0] OP_MUL6 = 4'd10;  // p = |s| * 1/6
  localparam logic [3:0] OP_Y6   = 4'd11;  // y = arg = y + signed p >> 32
  localparam logic [3:0] OP_DONE = 4'd12;  // no datapath action

  // Stage argument selection
  localparam logic [1:0] XS_BASE = 2'd0;
  localparam logic [1:0] XS_HALF = 2'd1;
  localparam logic [1:0] XS_FULL = 2'd2;

  // Program layout
  localparam logic [PC_W-1:0] PC_START = 6'd0;
  localparam logic [PC_W-1:0] PC_DONE  = 6'd35;

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] xsel;
    logic       loop;   // jump back to the start while steps remain
  } ucode_t;

  typedef struct packed {
    data_t x_re;
    data_t x_im;
    data_t y_re;
    data_t y_im;
    logic  last_in;
  } in_t;

  typedef struct packed {
    data_t out_re;
    data_t out_im;
    logic  saturated;
    logic  last_out;
  } out_t;

  typedef struct packed {
    data_t value;
    logic  ovf;
  } sat_t;

  // Saturating add
  function automatic sat_t sat_add(data_t a, data_t b);
    logic signed [DATA_W:0] sum;
    sat_t res;
    sum = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (sum[DATA_W] != sum[DATA_W-1]) begin
      res.value = sum[DATA_W] ? DATA_MIN : DATA_MAX;
      res.ovf   = 1'b1;
    end else begin
      res.value = sum[DATA_W-1:0];
      res.ovf   = 1'b0;
    end
    return res;
  endfunction

  // Saturating negate
  function automatic sat_t sat_neg(data_t a);
    sat_t res;
    if (a == DATA_MIN) begin
      res.value = DATA_MAX;
      res.ovf   = 1'b1;
    end else begin
      res.value = -a;
      res.ovf   = 1'b0;
    end
    return res;
  endfunction

  function automatic ucode_t uc_word(logic [3:0] op, logic [1:0] xsel, logic loop);
    ucode_t w;
    w.op   = op;
    w.xsel = xsel;
    w.loop = loop;
    return w;
  endfunction

  // Microcode ROM: one RK4 step for both parts, then the hand-off word
  function automatic ucode_t uc_fetch(logic [PC_W-1:0] pc);
    ucode_t w;
    unique case (pc)
      // stage one: k1 from (x, y)
      6'd0:  w = uc_word(OP_NEG,  XS_BASE, 1'b0);
      6'd1:  w = uc_word(OP_DBL,  XS_BASE, 1'b0);
      6'd2:  w = uc_word(OP_ADDX, XS_BASE, 1'b0);
      6'd3:  w = uc_word(OP_ADDC, XS_BASE, 1'b0);
      6'd4:  w = uc_word(OP_MULK, XS_BASE, 1'b0);
      6'd5:  w = uc_word(OP_SATK, XS_BASE, 1'b0);
      6'd6:  w = uc_word(OP_SUMI, XS_BASE, 1'b0);
      6'd7:  w = uc_word(OP_ARGH, XS_BASE, 1'b0);
      // stage two: k2 from (x + dx/2, y + k1/2)
      6'd8:  w = uc_word(OP_NEG,  XS_HALF, 1'b0);
      6'd9:  w = uc_word(OP_DBL,  XS_HALF, 1'b0);
      6'd10: w = uc_word(OP_ADDX, XS_HALF, 1'b0);
      6'd11: w = uc_word(OP_ADDC, XS_HALF, 1'b0);
      6'd12: w = uc_word(OP_MULK, XS_HALF, 1'b0);
      6'd13: w = uc_word(OP_SATK, XS_HALF, 1'b0);
      6'd14: w = uc_word(OP_SUMA, XS_HALF, 1'b0);
      6'd15: w = uc_word(OP_SUMA, XS_HALF, 1'b0);
      6'd16: w = uc_word(OP_ARGH, XS_HALF, 1'b0);
      // stage three: k3 from (x + dx/2, y + k2/2)
      6'd17: w = uc_word(OP_NEG,  XS_HALF, 1'b0);
      6'd18: w = uc_word(OP_DBL,  XS_HALF, 1'b0);
      6'd19: w = uc_word(OP_ADDX, XS_HALF, 1'b0);
      6'd20: w = uc_word(OP_ADDC, XS_HALF, 1'b0);
      6'd21: w = uc_word(OP_MULK, XS_HALF, 1'b0);
      6'd22: w = uc_word(OP_SATK, XS_HALF, 1'b0);
      6'd23: w = uc_word(OP_SUMA, XS_HALF, 1'b0);
      6'd24: w = uc_word(OP_SUMA, XS_HALF, 1'b0);
      6'd25: w = uc_word(OP_ARGF, XS_HALF, 1'b0);
      // stage four: k4 from (x + dx, y + k3), then y += sum/6
      6'd26: w = uc_word(OP_NEG,  XS_FULL, 1'b0);
      6'd27: w = uc_word(OP_DBL,  XS_FULL, 1'b0);
      6'd28: w = uc_word(OP_ADDX, XS_FULL, 1'b0);
      6'd29: w = uc_word(OP_ADDC, XS_FULL, 1'b0);
      6'd30: w = uc_word(OP_MULK, XS_FULL, 1'b0);
      6'd31: w = uc_word(OP_SATK, XS_FULL, 1'b0);
      6'd32: w = uc_word(OP_SUMA, XS_FULL, 1'b0);
      6'd33: w = uc_word(OP_MUL6, XS_FULL, 1'b0);
      6'd34: w = uc_word(OP_Y6,   XS_FULL, 1'b1);
      default: w = uc_word(OP_DONE, XS_BASE, 1'b0);
    endcase
    return w;
  endfunction

endpackage

[hdl/rk4_lane.sv]
// ============================================================================
// rk4_lane
// Datapath for one part (real or imaginary) of the element: a saturating
// adder, one 32x32 multiplier and the working registers, driven one
// microcode word per cycle.
// ============================================================================
module rk4_lane (
  input  logic                            clk,
  input  logic                            load,
  input  rk4_pkg::data_t                  y_init,
  input  rk4_pkg::data_t                  x_base,
  input  rk4_pkg::data_t                  x_half,
  input  rk4_pkg::data_t                  x_full,
  input  rk4_pkg::data_t                  c_val,
  input  logic [rk4_pkg::STEP_W-1:0]      dx,
  input  rk4_pkg::ucode_t                 uc,
  output rk4_pkg::data_t                  y,
  output logic                            sat
);

  localparam int FRAC_SHIFT = rk4_pkg::FRAC_W;

  rk4_pkg::data_t y_r, y_nxt;
  rk4_pkg::data_t arg_r, arg_nxt;
  rk4_pkg::data_t t_r, t_nxt;
  rk4_pkg::data_t k_r, k_nxt;
  rk4_pkg::data_t s_r, s_nxt;
  logic [rk4_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic neg_r, neg_nxt;
  logic sat_r, sat_nxt;

  rk4_pkg::data_t x_sel;
  rk4_pkg::data_t mul_src;
  logic [rk4_pkg::DATA_W-1:0] mul_mag;
  logic [rk4_pkg::DATA_W-1:0] mul_b;
  logic [rk4_pkg::PROD_W-FRAC_SHIFT-1:0] k_um;
  logic [rk4_pkg::DATA_W-1:0] k_mag;
  logic [rk4_pkg::DATA_W-1:0] k_half_mag;
  rk4_pkg::data_t k_half;
  logic [rk4_pkg::DATA_W-1:0] q_mag;
  rk4_pkg::data_t q_signed;
  rk4_pkg::sat_t add_res;
  logic ovf;

  // Select the stage argument
  always_comb begin
    case (uc.xsel)
      rk4_pkg::XS_HALF: x_sel = x_half;
      rk4_pkg::XS_FULL: x_sel = x_full;
      default:          x_sel = x_base;
    endcase
  end

  // Magnitude multiplier: by dx for a stage, by the reciprocal of six for the sum
  always_comb begin
    mul_src = (uc.op == rk4_pkg::OP_MUL6) ? s_r : t_r;
    mul_mag = mul_src[rk4_pkg::DATA_W-1] ? (~mul_src + 32'd1) : mul_src;
    mul_b   = (uc.op == rk4_pkg::OP_MUL6) ? rk4_pkg::RECIP_SIX
                                          : {{(rk4_pkg::DATA_W-rk4_pkg::STEP_W){1'b0}}, dx};
  end

  // Helpers: scaled product, halved k, sixth of the sum
  always_comb begin
    k_um       = prod_r[rk4_pkg::PROD_W-1:FRAC_SHIFT];
    k_mag      = k_r[rk4_pkg::DATA_W-1] ? (~k_r + 32'd1) : k_r;
    k_half_mag = k_mag >> 1;
    k_half     = k_r[rk4_pkg::DATA_W-1] ? (~k_half_mag + 32'd1) : k_half_mag;
    q_mag      = prod_r[rk4_pkg::PROD_W-1:rk4_pkg::DATA_W];
    q_signed   = neg_r ? (~q_mag + 32'd1) : q_mag;
  end

  // Execute the current operation
  always_comb begin
    y_nxt    = y_r;
    arg_nxt  = arg_r;
    t_nxt    = t_r;
    k_nxt    = k_r;
    s_nxt    = s_r;
    prod_nxt = prod_r;
    neg_nxt  = neg_r;
    ovf      = 1'b0;
    add_res  = '0;
    unique case (uc.op)
      rk4_pkg::OP_NEG: begin
        add_res = rk4_pkg::sat_neg(arg_r);
        t_nxt   = add_res.value;
        ovf     = add_res.ovf;
      end
      rk4_pkg::OP_DBL: begin
        add_res = rk4_pkg::sat_add(t_r, t_r);
        t_nxt   = add_res.value;
        ovf     = add_res.ovf;
      end
      rk4_pkg::OP_ADDX: begin
        add_res = rk4_pkg::sat_add(t_r, x_sel);
        t_nxt   = add_res.value;
        ovf     = add_res.ovf;
      end
      rk4_pkg::OP_ADDC: begin
        add_res = rk4_pkg::sat_add(t_r, c_val);
        t_nxt   = add_res.value;
        ovf     = add_res.ovf;
      end
      rk4_pkg::OP_MULK, rk4_pkg::OP_MUL6: begin
        prod_nxt = mul_mag * mul_b;
        neg_nxt  = mul_src[rk4_pkg::DATA_W-1];
      end
      rk4_pkg::OP_SATK: begin
        if (!neg_r) begin
          if (k_um > {{(rk4_pkg::PROD_W-FRAC_SHIFT-rk4_pkg::DATA_W){1'b0}}, rk4_pkg::DATA_MAX})
          begin
            k_nxt = rk4_pkg::DATA_MAX;
            ovf   = 1'b1;
          end else begin
            k_nxt = k_um[rk4_pkg::DATA_W-1:0];
          end
        end else begin
          if (k_um > {{(rk4_pkg::PROD_W-FRAC_SHIFT-rk4_pkg::DATA_W){1'b0}}, rk4_pkg::DATA_MIN})
          begin
            k_nxt = rk4_pkg::DATA_MIN;
            ovf   = 1'b1;
          end else begin
            k_nxt = ~k_um[rk4_pkg::DATA_W-1:0] + 32'd1;
          end
        end
      end
      rk4_pkg::OP_SUMI: begin
        s_nxt = k_r;
      end
      rk4_pkg::OP_SUMA: begin
        add_res = rk4_pkg::sat_add(s_r, k_r);
        s_nxt   = add_res.value;
        ovf     = add_res.ovf;
      end
      rk4_pkg::OP_ARGH: begin
        add_res = rk4_pkg::sat_add(y_r, k_half);
        arg_nxt = add_res.value;
        ovf     = add_res.ovf;
      end
      rk4_pkg::OP_ARGF: begin
        add_res = rk4_pkg::sat_add(y_r, k_r);
        arg_nxt = add_res.value;
        ovf     = add_res.ovf;
      end
      rk4_pkg::OP_Y6: begin
        add_res = rk4_pkg::sat_add(y_r, q_signed);
        y_nxt   = add_res.value;
        arg_nxt = add_res.value;
        ovf     = add_res.ovf;
      end
      default: begin
      end
    endcase
    sat_nxt = sat_r | ovf;
    // Load a fresh element over whatever the program was doing
    if (load) begin
      y_nxt   = y_init;
      arg_nxt = y_init;
      sat_nxt = 1'b0;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    y_r    <= y_nxt;
    arg_r  <= arg_nxt;
    t_r    <= t_nxt;
    k_r    <= k_nxt;
    s_r    <= s_nxt;
    prod_r <= prod_nxt;
    neg_r  <= neg_nxt;
    sat_r  <= sat_nxt;
  end

  assign y   = y_r;
  assign sat = sat_r;

endmodule

[hdl/rk4_linear_ode_complex_step_unit.sv]
// ============================================================================
// rk4_linear_ode_complex_step_unit
// Classical RK4 integration of dy/dx = -2y + x + 4 for one complex element,
// run by a microcoded sequencer over two datapath lanes.
// ============================================================================
// Usage:
//   Input channel (in_valid / in_stall / in_data) takes one request per
//   element: complex x, complex initial y and a last marker. Result channel
//   (out_valid / out_stall / out_data) returns the integrated y, a saturation
//   flag and the copied marker. cfg_we / cfg_index / cfg_wdata set the step
//   size and step count; write them only while the block is idle.
//   Each request runs step_count passes of a 35-word program (one word per
//   cycle, real and imaginary lanes in parallel, one multiplier per lane),
//   then the hand-off word that moves the result to the output register;
//   no new request is taken from acceptance until that hand-off is done.
//   The output register frees the input side: the next request is taken
//   while a finished result still waits. If the receiver stalls and that
//   result is still held, the sequencer holds on its hand-off word.
//   Reset drops any request in flight, empties the output register and
//   restores step size 13107 (about 0.2) and step count 10.
// ============================================================================
module rk4_linear_ode_complex_step_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  rk4_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output rk4_pkg::out_t                 out_data,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [rk4_pkg::STEP_W-1:0]    cfg_wdata
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_r, state_nxt;
  logic [rk4_pkg::PC_W-1:0] pc_r, pc_nxt;
  logic [rk4_pkg::COUNT_W-1:0] steps_r, steps_nxt;
  logic [rk4_pkg::STEP_W-1:0] step_size_r, step_size_nxt;
  logic [rk4_pkg::COUNT_W-1:0] step_count_r, step_count_nxt;
  logic out_valid_r, out_valid_nxt;
  rk4_pkg::out_t out_r, out_nxt;

  rk4_pkg::data_t x_re_r, x_im_r, xh_r, xf_r;
  logic pre_sat_r, last_r;

  logic in_accept;
  logic out_free;
  rk4_pkg::ucode_t uc_cur;
  rk4_pkg::ucode_t uc_exec;
  rk4_pkg::sat_t xh_res, xf_res;
  rk4_pkg::data_t y_re, y_im;
  logic sat_re, sat_im;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid & ~in_stall;
  assign out_free  = ~out_valid_r | ~out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Fetch the control word; idle cycles issue the no-action word
  always_comb begin
    uc_cur  = rk4_pkg::uc_fetch(pc_r);
    uc_exec = (state_r == ST_RUN) ? uc_cur
                                  : rk4_pkg::uc_word(rk4_pkg::OP_DONE, rk4_pkg::XS_BASE, 1'b0);
  end

  // Shifted stage arguments for the real part
  always_comb begin
    xh_res = rk4_pkg::sat_add(in_data.x_re,
                              {{(rk4_pkg::DATA_W-rk4_pkg::STEP_W+1){1'b0}},
                               step_size_r[rk4_pkg::STEP_W-1:1]});
    xf_res = rk4_pkg::sat_add(in_data.x_re,
                              {{(rk4_pkg::DATA_W-rk4_pkg::STEP_W){1'b0}}, step_size_r});
  end

  // Configuration writes
  always_comb begin
    step_size_nxt  = step_size_r;
    step_count_nxt = step_count_r;
    if (cfg_we) begin
      unique case (cfg_index)
        rk4_pkg::CFG_STEP_SIZE:  step_size_nxt  = cfg_wdata;
        rk4_pkg::CFG_STEP_COUNT: step_count_nxt = cfg_wdata[rk4_pkg::COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer: step counter, loop jump and hand-off to the output register
  always_comb begin
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    steps_nxt     = steps_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_nxt       = out_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_RUN;
          steps_nxt = step_count_r;
          pc_nxt    = (step_count_r == '0) ? rk4_pkg::PC_DONE : rk4_pkg::PC_START;
        end
      end
      ST_RUN: begin
        if (uc_cur.op == rk4_pkg::OP_DONE) begin
          if (out_free) begin
            out_nxt.out_re    = y_re;
            out_nxt.out_im    = y_im;
            out_nxt.saturated = pre_sat_r | sat_re | sat_im;
            out_nxt.last_out  = last_r;
            out_valid_nxt     = 1'b1;
            state_nxt         = ST_IDLE;
          end
        end else if (uc_cur.loop && (steps_r != rk4_pkg::COUNT_W'(1))) begin
          pc_nxt    = rk4_pkg::PC_START;
          steps_nxt = steps_r - rk4_pkg::COUNT_W'(1);
        end else begin
          pc_nxt = pc_r + rk4_pkg::PC_W'(1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pc_r         <= rk4_pkg::PC_START;
      steps_r      <= '0;
      step_size_r  <= rk4_pkg::STEP_W'(13107);
      step_count_r <= rk4_pkg::COUNT_W'(10);
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pc_r         <= pc_nxt;
      steps_r      <= steps_nxt;
      step_size_r  <= step_size_nxt;
      step_count_r <= step_count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers: hold x, shifted arguments and the marker per request
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (in_accept) begin
      x_re_r    <= in_data.x_re;
      x_im_r    <= in_data.x_im;
      xh_r      <= xh_res.value;
      xf_r      <= xf_res.value;
      pre_sat_r <= xh_res.ovf | xf_res.ovf;
      last_r    <= in_data.last_in;
    end
  end

  // Real lane carries the constant four and the shifted arguments
  rk4_lane u_lane_re (
    .clk    (clk),
    .load   (in_accept),
    .y_init (in_data.y_re),
    .x_base (x_re_r),
    .x_half (xh_r),
    .x_full (xf_r),
    .c_val  (rk4_pkg::FOUR_FX),
    .dx     (step_size_r),
    .uc     (uc_exec),
    .y      (y_re),
    .sat    (sat_re)
  );

  // Imaginary lane: no step shift, no constant
  rk4_lane u_lane_im (
    .clk    (clk),
    .load   (in_accept),
    .y_init (in_data.y_im),
    .x_base (x_im_r),
    .x_half (x_im_r),
    .x_full (x_im_r),
    .c_val  (rk4_pkg::ZERO_FX),
    .dx     (step_size_r),
    .uc     (uc_exec),
    .y      (y_im),
    .sat    (sat_im)
  );

  // A result appears only from the hand-off word of a running program
  a_out_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(state_r == ST_RUN))
    else $error("result appeared without a finished program");

  // The loop jump never sees an exhausted step counter
  a_steps_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && uc_cur.loop) |-> (steps_r != '0))
    else $error("loop word reached with no steps left");

  // The program counter stays inside the program
  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (pc_r <= rk4_pkg::PC_DONE))
    else $error("program counter outside the microcode");

  // A held result is not overwritten while the receiver stalls
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_r)))
    else $error("stalled result changed");

endmodule

[tb/tb_rk4_linear_ode_complex_step_unit.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb_rk4_linear_ode_complex_step_unit
// Self-checking bench for the RK4 complex step unit. Every accepted request is
// integrated by a bit-exact fixed-point predictor and the expected result is
// queued. Each returned result is checked field by field against the oldest
// expectation. Directed tests cover the field and register extremes and the
// saturating paths. Random traffic then runs under several register settings
// with bursty idling on both channels, followed by a closing stretch at full
// rate.
// ============================================================================
module tb_rk4_linear_ode_complex_step_unit;

  localparam longint VAL_MAX    = longint'(rk4_pkg::DATA_MAX);
  localparam longint VAL_MIN    = longint'(rk4_pkg::DATA_MIN);
  localparam int     CHUNK_LEN  = 50;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  rk4_pkg::in_t  in_data;
  logic       out_valid;
  logic       out_stall = 1'b0;
  rk4_pkg::out_t out_data;
  logic       cfg_we;
  logic       cfg_index;
  logic [rk4_pkg::STEP_W-1:0] cfg_wdata;

  // Predictor copy of the registers
  logic [rk4_pkg::STEP_W-1:0]  step_dx;
  logic [rk4_pkg::COUNT_W-1:0] step_n;
  bit                 sat_seen;

  rk4_pkg::out_t pending_results[$];
  rk4_pkg::out_t want;
  int   mismatch_count;
  bit   src_jitter;
  bit   sink_jitter;
  int   stall_left;

  rk4_linear_ode_complex_step_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Fixed-point predictor
  // --------------------------------------------------------------------------
  function automatic longint clip_add(longint a, longint b);
    if (b > 0 && a > VAL_MAX - b) begin
      sat_seen = 1'b1;
      return VAL_MAX;
    end
    if (b < 0 && a < VAL_MIN - b) begin
      sat_seen = 1'b1;
      return VAL_MIN;
    end
    return a + b;
  endfunction

  function automatic longint clip_neg(longint a);
    if (a == VAL_MIN) begin
      sat_seen = 1'b1;
      return VAL_MAX;
    end
    return -a;
  endfunction

  // Multiply the magnitude, truncate toward zero, then restore the sign
  function automatic longint scale_mag(longint a, longint unsigned m, int sh);
    bit neg;
    longint unsigned mag;
    longint unsigned prod;
    neg  = (a < 0);
    mag  = neg ? longint'(-a) : a;
    prod = (mag * m) >> sh;
    if (prod == 0) return 0;
    if (!neg) begin
      if (prod > VAL_MAX) begin
        sat_seen = 1'b1;
        return VAL_MAX;
      end
      return longint'(prod);
    end
    if (prod > VAL_MAX + 1) begin
      sat_seen = 1'b1;
      return VAL_MIN;
    end
    return -longint'(prod);
  endfunction

  function automatic longint halve(longint a);
    longint unsigned mag;
    mag = (a < 0) ? longint'(-a) : a;
    return (a < 0) ? -longint'(mag >> 1) : longint'(mag >> 1);
  endfunction

  // -2y + x + c
  function automatic longint slope(longint x, longint y, longint c);
    longint t;
    t = clip_neg(y);
    t = clip_add(t, t);
    t = clip_add(t, x);
    return clip_add(t, c);
  endfunction

  function automatic longint rk4_pass(longint x, longint y, longint xh, longint xf,
                                     longint c, longint unsigned dx);
    longint k1, k2, k3, k4, s;
    k1 = scale_mag(slope(x, y, c), dx, rk4_pkg::FRAC_W);
    k2 = scale_mag(slope(xh, clip_add(y, halve(k1)), c), dx, rk4_pkg::FRAC_W);
    k3 = scale_mag(slope(xh, clip_add(y, halve(k2)), c), dx, rk4_pkg::FRAC_W);
    k4 = scale_mag(slope(xf, clip_add(y, k3), c), dx, rk4_pkg::FRAC_W);
    s = clip_add(k1, k2);
    s = clip_add(s, k2);
    s = clip_add(s, k3);
    s = clip_add(s, k3);
    s = clip_add(s, k4);
    return clip_add(y, scale_mag(s, longint'(rk4_pkg::RECIP_SIX), 32));
  endfunction

  function automatic rk4_pkg::out_t integrate_element(rk4_pkg::in_t req);
    longint xr, xi, yr, yi, xh, xf;
    rk4_pkg::out_t res;
    sat_seen = 1'b0;
    xr = longint'(req.x_re);
    xi = longint'(req.x_im);
    yr = longint'(req.y_re);
    yi = longint'(req.y_im);
    xh = clip_add(xr, longint'(step_dx >> 1));
    xf = clip_add(xr, longint'(step_dx));
    for (int n = 0; n < int'(step_n); n++) begin
      yr = rk4_pass(xr, yr, xh, xf, longint'(rk4_pkg::FOUR_FX), longint'(step_dx));
      yi = rk4_pass(xi, yi, xi, xi, 0, longint'(step_dx));
    end
    res.out_re    = yr[rk4_pkg::DATA_W-1:0];
    res.out_im    = yi[rk4_pkg::DATA_W-1:0];
    res.saturated = sat_seen;
    res.last_out  = req.last_in;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  task automatic compare_field(input string name, input logic [rk4_pkg::DATA_W-1:0] exp_v,
                               input logic [rk4_pkg::DATA_W-1:0] got_v);
    if (exp_v !== got_v) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with nothing expected, expected none, actual %h %h %b %b",
                 $time, out_data.out_re, out_data.out_im, out_data.saturated,
                 out_data.last_out);
      end else begin
        want = pending_results.pop_front();
        compare_field("out_re", want.out_re, out_data.out_re);
        compare_field("out_im", want.out_im, out_data.out_im);
        compare_field("saturated", rk4_pkg::DATA_W'(want.saturated),
                      rk4_pkg::DATA_W'(out_data.saturated));
        compare_field("last_out", rk4_pkg::DATA_W'(want.last_out),
                      rk4_pkg::DATA_W'(out_data.last_out));
      end
    end
  end

  // Hold off results in random bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (sink_jitter && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 17);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Shared driving tasks
  // --------------------------------------------------------------------------
  // Offer one request and queue its expected result once it is taken
  task automatic push_element(input rk4_pkg::in_t req);
    @(negedge clk);
    if (src_jitter && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(integrate_element(req));
  endtask

  // Drop valid and hold until every expected result has come back
  task automatic wait_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic settle();
    wait_results();
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [rk4_pkg::STEP_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == rk4_pkg::CFG_STEP_SIZE) begin
      step_dx = val;
    end else begin
      step_n = val[rk4_pkg::COUNT_W-1:0];
    end
  endtask

  function automatic rk4_pkg::in_t make_element(rk4_pkg::data_t xr, rk4_pkg::data_t xi,
                                                rk4_pkg::data_t yr, rk4_pkg::data_t yi,
                                                logic lst);
    rk4_pkg::in_t e;
    e.x_re    = xr;
    e.x_im    = xi;
    e.y_re    = yr;
    e.y_im    = yi;
    e.last_in = lst;
    return e;
  endfunction

  // Spread magnitudes: extremes, scaled-down values and raw words
  function automatic rk4_pkg::data_t rand_value();
    rk4_pkg::data_t v;
    int pick;
    v    = $urandom;
    pick = $urandom_range(0, 15);
    if (pick == 0) begin
      v = rk4_pkg::DATA_MAX;
    end else if (pick == 1) begin
      v = rk4_pkg::DATA_MIN;
    end else if (pick < 10) begin
      v = v >>> $urandom_range(8, 30);
    end
    return v;
  endfunction

  function automatic rk4_pkg::in_t random_element();
    return make_element(rand_value(), rand_value(), rand_value(), rand_value(),
                        1'($urandom_range(0, 1)));
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset settings: field extremes, saturating negate and x + dx overflow
  task automatic test_reset_defaults();
    push_element(make_element(0, 0, 0, 0, 1'b0));
    push_element(make_element(32'sh0001_0000, 0, 32'sh0000_8000, -32'sh0000_8000, 1'b1));
    push_element(make_element(0, 0, rk4_pkg::DATA_MAX, rk4_pkg::DATA_MIN, 1'b0));
    push_element(make_element(rk4_pkg::DATA_MAX, rk4_pkg::DATA_MIN, 0, 0, 1'b0));
    push_element(make_element(rk4_pkg::DATA_MIN, rk4_pkg::DATA_MIN, rk4_pkg::DATA_MAX,
                              rk4_pkg::DATA_MAX, 1'b1));
    push_element(make_element(32'shAAAA_AAAA, 32'sh5555_5555, 32'sh5555_5555,
                              32'shAAAA_AAAA, 1'b1));
    push_element(make_element(-1, -1, -1, -1, 1'b0));
    push_element(make_element(-32'sh0004_0000, 0, 0, 0, 1'b0));
  endtask

  // No steps: y passes through, but x + dx may still saturate
  task automatic test_zero_steps();
    settle();
    write_reg(rk4_pkg::CFG_STEP_SIZE, 17'd65536);
    write_reg(rk4_pkg::CFG_STEP_COUNT, '0);
    push_element(random_element());
    push_element(make_element(rk4_pkg::DATA_MAX, 0, 32'sh1234_5678, -32'sh0765_4321, 1'b1));
    push_element(make_element(0, rk4_pkg::DATA_MAX, rk4_pkg::DATA_MIN, rk4_pkg::DATA_MAX,
                              1'b0));
  endtask

  // Zero step size, step size past 1.0 and a full 1.0 step
  task automatic test_step_size_extremes();
    settle();
    write_reg(rk4_pkg::CFG_STEP_SIZE, '0);
    write_reg(rk4_pkg::CFG_STEP_COUNT, 17'd3);
    push_element(make_element(32'sh0002_0000, -32'sh0001_0000, 32'sh0000_4000, 0, 1'b0));
    settle();
    write_reg(rk4_pkg::CFG_STEP_SIZE, '1);
    write_reg(rk4_pkg::CFG_STEP_COUNT, 17'd2);
    push_element(make_element(32'sh0001_8000, 32'sh0000_0100, -32'sh0003_0000,
                              32'sh0000_2000, 1'b1));
    push_element(make_element(32'sh4000_0000, -32'sh4000_0000, 32'sh3000_0000,
                              -32'sh3000_0000, 1'b0));
    settle();
    write_reg(rk4_pkg::CFG_STEP_SIZE, 17'd65536);
    write_reg(rk4_pkg::CFG_STEP_COUNT, 17'd1);
    push_element(make_element(0, 0, 32'sh6000_0000, -32'sh6000_0000, 1'b1));
  endtask

  // Upper write bits beyond the step count width are dropped
  task automatic test_count_masking();
    settle();
    write_reg(rk4_pkg::CFG_STEP_SIZE, 17'd1);
    write_reg(rk4_pkg::CFG_STEP_COUNT, 17'h1FC03);
    push_element(random_element());
  endtask

  // Longest program run: full step count at step size 1.0
  task automatic test_longest_run();
    settle();
    write_reg(rk4_pkg::CFG_STEP_SIZE, 17'd65536);
    write_reg(rk4_pkg::CFG_STEP_COUNT, 17'd1023);
    push_element(make_element(32'sh0000_8000, -32'sh0002_0000, 32'sh0001_0000,
                              32'sh0000_4000, 1'b0));
    push_element(make_element(rk4_pkg::DATA_MIN, rk4_pkg::DATA_MAX, rk4_pkg::DATA_MAX,
                              rk4_pkg::DATA_MIN, 1'b1));
  endtask

  // Random requests in chunks, each chunk under a fresh register setting
  task automatic test_random_traffic(input int chunks, input bit jitter);
    logic [rk4_pkg::STEP_W-1:0] size_word;
    logic [rk4_pkg::STEP_W-1:0] count_word;
    int pick;
    for (int c = 0; c < chunks; c++) begin
      settle();
      pick = $urandom_range(0, 7);
      if (pick == 0) begin
        size_word = '0;
      end else if (pick == 1) begin
        size_word = 17'd65536;
      end else if (pick == 2) begin
        size_word = '1;
      end else if (pick < 5) begin
        size_word = rk4_pkg::STEP_W'($urandom_range(0, 131071));
      end else begin
        size_word = rk4_pkg::STEP_W'($urandom_range(1000, 20000));
      end
      count_word = rk4_pkg::STEP_W'($urandom_range(0, 131071));
      count_word[rk4_pkg::COUNT_W-1:0] = ($urandom_range(0, 5) == 0)
                                         ? rk4_pkg::COUNT_W'($urandom_range(9, 24))
                                         : rk4_pkg::COUNT_W'($urandom_range(0, 8));
      write_reg(rk4_pkg::CFG_STEP_SIZE, size_word);
      write_reg(rk4_pkg::CFG_STEP_COUNT, count_word);
      src_jitter  = jitter && ($urandom_range(0, 3) != 0);
      sink_jitter = jitter && ($urandom_range(0, 3) != 0);
      for (int n = 0; n < CHUNK_LEN; n++) begin
        // now and then let the pipe run dry before the next request
        if (jitter && $urandom_range(0, 39) == 0) wait_results();
        push_element(random_element());
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_we         = 1'b0;
    cfg_index      = rk4_pkg::CFG_STEP_SIZE;
    cfg_wdata      = '0;
    step_dx        = 17'd13107;
    step_n         = 10'd10;
    mismatch_count = 0;
    stall_left     = 0;
    src_jitter     = 1'b1;
    sink_jitter    = 1'b1;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_zero_steps();
    test_step_size_extremes();
    test_count_masking();
    test_longest_run();
    test_random_traffic(20, 1'b1);
    test_random_traffic(1, 1'b0);

    wait_results();
    repeat (35 * int'(step_n) + 10) @(negedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #50_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
